[src/rlb_pkg.sv]
// Package for the RGB layer blend unit: blend mode codes, channel constants
// and the divide-by-255 helper. Depends on nothing.
package rlb_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned NUM_CHAN  = 3;
   localparam int unsigned PIXEL_W   = 32;
   localparam int unsigned OPACITY_W = 9;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned PROD_W    = 16;

   localparam logic [CHAN_W-1:0]    CHAN_MAX    = 8'hFF;
   localparam logic [CHAN_W-1:0]    ALPHA_BYTE  = 8'hFF;
   localparam logic [OPACITY_W-1:0] OPACITY_ONE = 9'd256;

   // Blend mode codes; codes 5 to 7 pass the destination through
   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_MULTIPLY = 3'd2,
      MODE_SCREEN   = 3'd3,
      MODE_OVERLAY  = 3'd4
   } blend_mode_type;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_MODE = 2'd0,
      CSR_OPACITY    = 2'd1
   } csr_index_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_type;
   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] prod_vec_type;

   // Exact x / 255 for x up to 65025: (x + (x >> 8) + 1) >> 8
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = {1'b0, x} + {9'b0, x[PROD_W-1:CHAN_W]} + 17'd1;
      return sum[PROD_W-1:CHAN_W];
   endfunction

endpackage

[src/rgb_layer_blend_unit.sv]
// Top level of the RGB layer blend unit: a three-stage pixel pipeline with
// blend mode and opacity registers. Depends on rlb_pkg.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_src_pixel, req_dst_pixel
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_out_pixel
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One pixel per clock while rsp_stall is low; a req beat is registered in
// stage 1, then stage 2, then stage 3, whose output drives the rsp beat.
// Stage 1 forms the per-channel product, stage 2 divides by 255 and
// saturates add, stage 3 mixes with the destination by opacity (not in add).
// Synchronous reset clears the stage valid bits and loads mode normal and
// opacity 256. Each stage holds while its successor is full and stalled;
// empty stages keep filling, so bubbles close up under rsp_stall.
module rgb_layer_blend_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rlb_pkg::PIXEL_W-1:0]  req_src_pixel,
   input  logic [rlb_pkg::PIXEL_W-1:0]  req_dst_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rlb_pkg::PIXEL_W-1:0]  rsp_out_pixel,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rlb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlb_pkg::OPACITY_W-1:0] csr_wdata
);
   import rlb_pkg::*;

   // Configuration registers; opacity is stored already saturated at 256
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [OPACITY_W-1:0] opacity_ff, opacity_in;

   // Stage valid bits and advance enables
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_en, s2_en, s3_en;

   // Stage payloads
   prod_vec_type          s1_prod_ff, s1_prod_in;
   chan_vec_type          s1_src_ff;
   logic [PIXEL_W-1:0]    s1_dst_ff;
   logic                  s1_bypass_ff, s1_bypass_in;
   chan_vec_type          s2_blend_ff, s2_blend_in;
   logic [PIXEL_W-1:0]    s2_dst_ff;
   logic                  s2_bypass_ff;
   logic [PIXEL_W-1:0]    s3_pixel_ff, s3_pixel_in;

   logic is_add;
   assign is_add = (mode_ff == MODE_ADD);

   // Accept every write; saturate opacity above one
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      opacity_in = opacity_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BLEND_MODE: mode_in    = csr_wdata[MODE_W-1:0];
            CSR_OPACITY:    opacity_in = csr_wdata[OPACITY_W-1] ? OPACITY_ONE : csr_wdata;
            default:        ;
         endcase
      end
   end

   // Advance a stage when it is empty or its successor frees up
   assign s3_en     = !s3_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   assign s1_valid_in = s1_en ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_en ? s2_valid_ff : s3_valid_ff;

   // Stage 1: pick multiplier operands per mode, one product per channel
   always_comb begin
      logic [CHAN_W-1:0]    s, d, sc, dc;
      logic [CHAN_W-1:0]    op_x;
      logic [OPACITY_W-1:0] op_y;
      logic [PROD_W:0]      prod;
      s1_prod_in = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         s  = req_src_pixel[k*CHAN_W +: CHAN_W];
         d  = req_dst_pixel[k*CHAN_W +: CHAN_W];
         sc = CHAN_MAX - s;
         dc = CHAN_MAX - d;
         case (mode_ff)
            MODE_ADD: begin
               op_x = s;
               op_y = opacity_ff;
            end
            MODE_MULTIPLY: begin
               op_x = s;
               op_y = {1'b0, d};
            end
            MODE_SCREEN: begin
               op_x = sc;
               op_y = {1'b0, dc};
            end
            MODE_OVERLAY: begin
               // doubled operand fits: the halved side stays below 128
               if (d[CHAN_W-1]) begin
                  op_x = sc;
                  op_y = {dc, 1'b0};
               end else begin
                  op_x = s;
                  op_y = {d, 1'b0};
               end
            end
            default: begin
               op_x = '0;
               op_y = '0;
            end
         endcase
         prod = {9'b0, op_x} * {8'b0, op_y};
         s1_prod_in[k] = prod[PROD_W-1:0];
      end
   end

   // Pass the destination untouched for unused modes and black normal source
   assign s1_bypass_in = (mode_ff > MODE_OVERLAY) ||
                         ((mode_ff == MODE_NORMAL) && (req_src_pixel[23:0] == 24'd0));

   // Stage 2: divide by 255, fold screen and overlay, saturate add
   always_comb begin
      logic [CHAN_W-1:0] s, d, q;
      logic [CHAN_W:0]   sum;
      s2_blend_in = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         s   = s1_src_ff[k];
         d   = s1_dst_ff[k*CHAN_W +: CHAN_W];
         q   = div255(s1_prod_ff[k]);
         sum = {1'b0, d} + {1'b0, s1_prod_ff[k][PROD_W-1:CHAN_W]};
         case (mode_ff)
            MODE_NORMAL:   s2_blend_in[k] = s;
            MODE_ADD:      s2_blend_in[k] = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
            MODE_MULTIPLY: s2_blend_in[k] = q;
            MODE_SCREEN:   s2_blend_in[k] = CHAN_MAX - q;
            MODE_OVERLAY:  s2_blend_in[k] = d[CHAN_W-1] ? (CHAN_MAX - q) : q;
            default:       s2_blend_in[k] = d;
         endcase
      end
   end

   // Stage 3: mix as d*256 + (m - d)*a, then drop the fraction; add mode passes m
   always_comb begin
      logic [CHAN_W-1:0]        m, d;
      logic signed [CHAN_W:0]   diff;
      logic signed [18:0]       acc;
      chan_vec_type             res;
      res = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         m    = s2_blend_ff[k];
         d    = s2_dst_ff[k*CHAN_W +: CHAN_W];
         diff = $signed({1'b0, m}) - $signed({1'b0, d});
         acc  = $signed({3'b0, d, 8'b0}) +
                (19'(diff) * 19'($signed({1'b0, opacity_ff})));
         res[k] = is_add ? m : acc[15:8];
      end
      s3_pixel_in = s2_bypass_ff ? s2_dst_ff : {ALPHA_BYTE, res[2], res[1], res[0]};
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         opacity_ff  <= OPACITY_ONE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         opacity_ff  <= opacity_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers; hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff   <= s1_prod_in;
         s1_src_ff    <= req_src_pixel[23:0];
         s1_dst_ff    <= req_dst_pixel;
         s1_bypass_ff <= s1_bypass_in;
      end
      if (s2_en) begin
         s2_blend_ff  <= s2_blend_in;
         s2_dst_ff    <= s1_dst_ff;
         s2_bypass_ff <= s1_bypass_ff;
      end
      if (s3_en) begin
         s3_pixel_ff  <= s3_pixel_in;
      end
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_out_pixel = s3_pixel_ff;

endmodule
